/* rtl/ffa_pkg.sv */
// Shared types, codes and sizing functions for the first-fit heap allocator.
// No dependencies; ffa_walk and the top level import this package.
`timescale 1ns / 1ps

package ffa_pkg;

    localparam int ADDR_W    = 32;
    localparam int REQ_W     = 17;
    localparam int HSIZE_W   = 17;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int HSIZE_MAX = (2 ** HSIZE_W) - 1;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LEN  = 1'b1;

    localparam logic [HSIZE_W-1:0] HEAP_LEN_RESET = 17'd65536;

    typedef struct packed {
        logic [ADDR_W-1:0]  heap_base;
        logic [HSIZE_W-1:0] heap_len;
    } t_cfg;

    typedef struct packed {
        logic              operation;
        logic [REQ_W-1:0]  request_size;
        logic [ADDR_W-1:0] address;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0]   result_address;
        logic [STATUS_W-1:0] status;
    } t_rsp;

    // largest heap the size register can describe under the build limit
    function automatic int f_max_heap(input int heap_bytes);
        return (heap_bytes < HSIZE_MAX) ? heap_bytes : HSIZE_MAX;
    endfunction

    // block offsets are multiples of the power of two shared by header and alignment
    function automatic int f_gran_shift(input int header_bytes, input int align_bytes);
        int s;
        int v;
        int k;
        s = 0;
        v = header_bytes | align_bytes;
        for (k = 0; k < 8; k++) begin
            if (((v & 1) == 0) && (s == k)) begin
                s = k + 1;
            end
            v = v >> 1;
        end
        return s;
    endfunction

endpackage

/* rtl/ffa_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ffa_walk.sv */
// Chain-walking sequencer: follows block headers in the header RAM, splits and merges.
// Depends on ffa_pkg; drives the ports of one ffa_ram instance.
`timescale 1ns / 1ps

module ffa_walk #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 12,
    parameter int ALIGN_BYTES  = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr,
    input  ffa_pkg::t_cfg i_cfg,
    input  logic         i_start,
    input  ffa_pkg::t_cmd i_cmd,
    input  logic         i_rsp_free,
    output logic         o_idle,
    output logic         o_done,
    output ffa_pkg::t_rsp o_rsp,
    output logic         o_mem_we,
    output logic [((((ffa_pkg::f_max_heap(HEAP_BYTES)
        + (1 << ffa_pkg::f_gran_shift(HEADER_BYTES, ALIGN_BYTES)) - 1)
        >> ffa_pkg::f_gran_shift(HEADER_BYTES, ALIGN_BYTES)) > 1)
        ? $clog2((ffa_pkg::f_max_heap(HEAP_BYTES)
        + (1 << ffa_pkg::f_gran_shift(HEADER_BYTES, ALIGN_BYTES)) - 1)
        >> ffa_pkg::f_gran_shift(HEADER_BYTES, ALIGN_BYTES)) : 1)-1:0] o_mem_waddr,
    output logic [$clog2(ffa_pkg::f_max_heap(HEAP_BYTES) + HEADER_BYTES + 1):0] o_mem_wdata,
    output logic         o_mem_re,
    output logic [((((ffa_pkg::f_max_heap(HEAP_BYTES)
        + (1 << ffa_pkg::f_gran_shift(HEADER_BYTES, ALIGN_BYTES)) - 1)
        >> ffa_pkg::f_gran_shift(HEADER_BYTES, ALIGN_BYTES)) > 1)
        ? $clog2((ffa_pkg::f_max_heap(HEAP_BYTES)
        + (1 << ffa_pkg::f_gran_shift(HEADER_BYTES, ALIGN_BYTES)) - 1)
        >> ffa_pkg::f_gran_shift(HEADER_BYTES, ALIGN_BYTES)) : 1)-1:0] o_mem_raddr,
    input  logic [$clog2(ffa_pkg::f_max_heap(HEAP_BYTES) + HEADER_BYTES + 1):0] i_mem_rdata
);

    import ffa_pkg::*;

    localparam int MAX_HEAP = f_max_heap(HEAP_BYTES);
    localparam int W        = $clog2(MAX_HEAP + HEADER_BYTES + 1);
    localparam int GS       = f_gran_shift(HEADER_BYTES, ALIGN_BYTES);
    localparam int DEPTH    = (MAX_HEAP + (1 << GS) - 1) >> GS;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NEED_W   = $clog2(HSIZE_MAX + ALIGN_BYTES);
    localparam int CW       = ((W > NEED_W) ? W : NEED_W) + 2;

    localparam logic [CW-1:0]     HDR_C   = CW'(HEADER_BYTES);
    localparam logic [NEED_W-1:0] ALIGN_M = NEED_W'(ALIGN_BYTES - 1);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_READ,
        S_EVAL,
        S_SPLIT,
        S_RD_NEXT,
        S_MERGE,
        S_DONE
    } t_state;

    t_state              r_state;
    logic                r_op;
    logic [REQ_W-1:0]    r_req;
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_target;
    logic [NEED_W-1:0]   r_need;
    logic [W-1:0]        r_usable;
    logic [W-1:0]        r_total;
    logic [W-1:0]        r_off;
    logic [W-1:0]        r_nxt;
    logic [W-1:0]        r_cur_size;
    logic                r_next_ok;
    logic                r_has_prev;
    logic                r_prev_free;
    logic [W-1:0]        r_prev_off;
    logic [W-1:0]        r_prev_size;
    logic [W-1:0]        r_split_off;
    logic [W-1:0]        r_split_size;
    logic [ADDR_W-1:0]   r_result;
    logic [STATUS_W-1:0] r_status;

    logic [W-1:0]        rd_size;
    logic                rd_free;
    logic [CW-1:0]       hs_c;
    logic [CW-1:0]       usable_c;
    logic [W-1:0]        init_size;
    logic [W-1:0]        init_total;
    logic [NEED_W-1:0]   need_sum;
    logic [NEED_W-1:0]   need_c;
    logic [ADDR_W:0]     end_c;
    logic                rel_ok;
    logic [CW-1:0]       off_h;
    logic [CW-1:0]       nxt_sum;
    logic                nxt_end;
    logic                fit;
    logic                split;
    logic [CW-1:0]       split_off_c;
    logic [CW-1:0]       split_size_c;
    logic                hit;
    logic                passed;
    logic [ADDR_W-1:0]   res_addr;
    logic                pf;
    logic                nf;
    logic [CW-1:0]       mrg_a;
    logic [CW-1:0]       mrg_sum;

    assign rd_size = i_mem_rdata[W-1:0];
    assign rd_free = i_mem_rdata[W];

    assign hs_c       = CW'(i_cfg.heap_len);
    assign usable_c   = (hs_c > CW'(MAX_HEAP)) ? CW'(MAX_HEAP) : hs_c;
    assign init_size  = (usable_c > HDR_C) ? W'(usable_c - HDR_C) : '0;
    assign init_total = (usable_c > HDR_C) ? W'(usable_c) : W'(HEADER_BYTES);

    assign need_sum = NEED_W'(r_req) + ALIGN_M;
    assign need_c   = need_sum & ~ALIGN_M;
    assign end_c    = {1'b0, i_cfg.heap_base} + (ADDR_W + 1)'(r_usable);
    assign rel_ok   = (i_cfg.heap_base != '0) && (r_addr != '0)
                   && (r_addr >= i_cfg.heap_base) && ({1'b0, r_addr} < end_c);

    assign off_h        = CW'(r_off) + HDR_C;
    assign nxt_sum      = off_h + CW'(rd_size);
    assign nxt_end      = nxt_sum >= CW'(r_total);
    assign fit          = rd_free && (CW'(rd_size) >= CW'(r_need));
    assign split        = CW'(rd_size) > (CW'(r_need) + HDR_C);
    assign split_off_c  = off_h + CW'(r_need);
    assign split_size_c = CW'(rd_size) - CW'(r_need) - HDR_C;
    assign hit          = ADDR_W'(off_h) == r_target;
    assign passed       = ADDR_W'(off_h) > r_target;
    assign res_addr     = i_cfg.heap_base + ADDR_W'(r_off) + ADDR_W'(HEADER_BYTES);

    assign pf      = r_has_prev && r_prev_free;
    assign nf      = r_next_ok && rd_free;
    assign mrg_a   = (pf ? (CW'(r_prev_size) + HDR_C) : '0) + CW'(r_cur_size);
    assign mrg_sum = mrg_a + (nf ? (HDR_C + CW'(rd_size)) : '0);

    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_off[AW+GS-1:GS];
        o_mem_wdata = '0;
        unique case (r_state)
            S_INIT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = '0;
                o_mem_wdata = {1'b1, init_size};
            end
            S_EVAL: begin
                if ((r_op == OP_ALLOC) && fit) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = {1'b0, split ? W'(r_need) : rd_size};
                end
            end
            S_SPLIT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_split_off[AW+GS-1:GS];
                o_mem_wdata = {1'b1, r_split_size};
            end
            S_MERGE: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = pf ? r_prev_off[AW+GS-1:GS] : r_off[AW+GS-1:GS];
                o_mem_wdata = {1'b1, W'(mrg_sum)};
            end
            default: begin
                o_mem_we = 1'b0;
            end
        endcase
    end

    assign o_mem_re    = (r_state == S_READ) || (r_state == S_RD_NEXT);
    assign o_mem_raddr = (r_state == S_RD_NEXT) ? r_nxt[AW+GS-1:GS] : r_off[AW+GS-1:GS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else if (i_cfg_wr) begin
            r_state <= S_INIT;
        end else begin
            unique case (r_state)
                S_INIT: begin
                    r_usable <= W'(usable_c);
                    r_total  <= init_total;
                    r_state  <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_op    <= i_cmd.operation;
                        r_req   <= i_cmd.request_size;
                        r_addr  <= i_cmd.address;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_result   <= '0;
                    r_off      <= '0;
                    r_has_prev <= 1'b0;
                    r_need     <= need_c;
                    r_target   <= r_addr - i_cfg.heap_base;
                    if (r_op == OP_ALLOC) begin
                        if ((r_req == '0) || (i_cfg.heap_base == '0)) begin
                            r_status <= ST_NOFIT;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end else if (!rel_ok) begin
                        r_status <= ST_IGNORED;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (r_op == OP_ALLOC) begin
                        if (fit) begin
                            r_result     <= res_addr;
                            r_status     <= ST_DONE;
                            r_split_off  <= W'(split_off_c);
                            r_split_size <= W'(split_size_c);
                            r_state      <= split ? S_SPLIT : S_DONE;
                        end else if (nxt_end) begin
                            r_status <= ST_NOFIT;
                            r_state  <= S_DONE;
                        end else begin
                            r_off   <= W'(nxt_sum);
                            r_state <= S_READ;
                        end
                    end else begin
                        if (hit) begin
                            r_cur_size <= rd_size;
                            r_nxt      <= W'(nxt_sum);
                            r_next_ok  <= !nxt_end;
                            r_state    <= S_RD_NEXT;
                        end else if (passed || nxt_end) begin
                            r_status <= ST_IGNORED;
                            r_state  <= S_DONE;
                        end else begin
                            r_has_prev  <= 1'b1;
                            r_prev_free <= rd_free;
                            r_prev_off  <= r_off;
                            r_prev_size <= rd_size;
                            r_off       <= W'(nxt_sum);
                            r_state     <= S_READ;
                        end
                    end
                end
                S_SPLIT: begin
                    r_state <= S_DONE;
                end
                S_RD_NEXT: begin
                    r_state <= S_MERGE;
                end
                S_MERGE: begin
                    r_status <= ST_DONE;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (i_rsp_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

    assign o_idle                = (r_state == S_IDLE);
    assign o_done                = (r_state == S_DONE);
    assign o_rsp.result_address  = r_result;
    assign o_rsp.status          = r_status;

endmodule

/* rtl/first_fit_heap_allocator.sv */
// First-fit heap allocator with coalescing: top level holding the configuration
// registers, the block header RAM (ffa_ram), the chain walker (ffa_walk) and the
// result register; depends on ffa_pkg. Block headers sit in the RAM at their own
// heap offset, so the chain is followed header by header through one read port.
// An allocate walks the blocks up to and including the one that fits and then
// writes a free header for the remainder when the block is split; a release
// walks the blocks up to the released one and reads the block after it, with
// its neighbors merged in a single write. Null allocations and out-of-range
// releases finish without walking the chain. After reset and after every
// configuration write the heap is rebuilt as one free block, during which no
// word is accepted. ALIGN_BYTES must be a power of two.
`timescale 1ns / 1ps

module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 12,
    parameter int ALIGN_BYTES  = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ffa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ffa_pkg::ADDR_W-1:0]        i_cfg_data,
    input  logic                              i_req_valid,
    output logic                              o_req_stall,
    input  logic                              i_operation,
    input  logic [ffa_pkg::REQ_W-1:0]         i_request_size,
    input  logic [ffa_pkg::ADDR_W-1:0]        i_address,
    output logic                              o_rsp_valid,
    input  logic                              i_rsp_stall,
    output logic [ffa_pkg::ADDR_W-1:0]        o_result_address,
    output logic [ffa_pkg::STATUS_W-1:0]      o_status
);

    import ffa_pkg::*;

    localparam int MAX_HEAP = f_max_heap(HEAP_BYTES);
    localparam int OFF_W    = $clog2(MAX_HEAP + HEADER_BYTES + 1);
    localparam int GS       = f_gran_shift(HEADER_BYTES, ALIGN_BYTES);
    localparam int DEPTH    = (MAX_HEAP + (1 << GS) - 1) >> GS;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW       = OFF_W + 1;

    logic [ADDR_W-1:0]   r_heap_base;
    logic [HSIZE_W-1:0]  r_heap_len;
    logic                r_rsp_valid;
    logic [ADDR_W-1:0]   r_result_address;
    logic [STATUS_W-1:0] r_status;

    t_cfg          cfg;
    t_cmd          cmd;
    t_rsp          walk_rsp;
    logic          walk_idle;
    logic          walk_done;
    logic          rsp_free;
    logic          start;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
            r_heap_len  <= HEAP_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEAP_BASE: r_heap_base <= i_cfg_data;
                CFG_HEAP_LEN:  r_heap_len  <= i_cfg_data[HSIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.heap_base    = r_heap_base;
    assign cfg.heap_len     = r_heap_len;
    assign cmd.operation    = i_operation;
    assign cmd.request_size = i_request_size;
    assign cmd.address      = i_address;

    assign o_req_stall = !walk_idle || i_cfg_we;
    assign start       = i_req_valid && !o_req_stall;
    assign rsp_free    = !r_rsp_valid || !i_rsp_stall;

    ffa_walk #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_we),
        .i_cfg       (cfg),
        .i_start     (start),
        .i_cmd       (cmd),
        .i_rsp_free  (rsp_free),
        .o_idle      (walk_idle),
        .o_done      (walk_done),
        .o_rsp       (walk_rsp),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    ffa_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (walk_done && rsp_free) begin
            r_rsp_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (walk_done && rsp_free) begin
            r_result_address <= walk_rsp.result_address;
            r_status         <= walk_rsp.status;
        end
    end

    assign o_rsp_valid      = r_rsp_valid;
    assign o_result_address = r_result_address;
    assign o_status         = r_status;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |=> o_req_stall)
        else $error("block took a second word while the first was in flight");

    a_null_on_failure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_status != ST_DONE)) |-> (o_result_address == '0))
        else $error("failed or ignored word carries a nonzero address");

    a_rebuild_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_req_stall)
        else $error("word accepted before the heap was rebuilt");
`endif

endmodule
